@@ src/fdp_pkg.sv @@
package fdp_pkg;

    // operand width of the arithmetic
    localparam int VALUE_BITS = 16;
    // field widths fixed by the interface
    localparam int IN_BITS  = 16;
    localparam int OUT_BITS = 16;
    // exponent of one prime in m never reaches VALUE_BITS
    localparam int EXP_BITS = (VALUE_BITS > 2) ? $clog2(VALUE_BITS) : 1;
    // running square of the trial divisor needs two guard bits
    localparam int SQ_BITS  = VALUE_BITS + 2;
    // step counter of the divider
    localparam int STEP_BITS = $clog2(VALUE_BITS);

    localparam logic [OUT_BITS-1:0] POWER_MAX = {OUT_BITS{1'b1}};

    // operand pair fed to the shared divider
    typedef enum logic [1:0] {
        DIV_TRIAL = 2'd0,   // m / d
        DIV_LEG   = 2'd1,   // t / p
        DIV_EXP   = 2'd2    // total / e
    } div_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     trial_take;
        logic     trial_prime;
        logic     tail_prime;
        logic     next_d;
        logic     leg_init;
        logic     leg_acc;
        logic     fold;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic dsq_le_m;
        logic m_gt1;
        logic div_done;
        logic rem_zero;
        logic e_nonzero;
        logic t_zero;
    } status_t;

endpackage

@@ src/fdp_div.sv @@
module fdp_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [fdp_pkg::VALUE_BITS-1:0] dividend,
    input  logic [fdp_pkg::VALUE_BITS-1:0] divisor,
    output logic                           done,
    output logic [fdp_pkg::VALUE_BITS-1:0] quotient,
    output logic [fdp_pkg::VALUE_BITS-1:0] remainder
);
    import fdp_pkg::*;

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [STEP_BITS-1:0]  cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [VALUE_BITS-1:0] dvs_reg, dvs_next;
    logic [VALUE_BITS:0]   shifted;
    logic                  fits;

    // one restoring step per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[VALUE_BITS-1]};
        fits      = shifted >= {1'b0, dvs_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = STEP_BITS'(VALUE_BITS - 1);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = fits ? VALUE_BITS'(shifted - {1'b0, dvs_reg})
                            : VALUE_BITS'(shifted);
            quo_next = {quo_reg[VALUE_BITS-2:0], fits};
            cnt_next = cnt_reg - STEP_BITS'(1);
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef NO_ASSERTIONS
    // never restarted in the middle of a division
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg)
        else $error("divider restarted while running");
    // done follows the last step only
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(run_reg))
        else $error("divider done without a running division");
    // done lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");
`endif
endmodule

@@ src/fdp_datapath.sv @@
module fdp_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fdp_pkg::cmd_t                cmd,
    input  logic [fdp_pkg::IN_BITS-1:0]  divisor_base,
    input  logic [fdp_pkg::IN_BITS-1:0]  factorial_arg,
    output fdp_pkg::status_t             status,
    output logic [fdp_pkg::OUT_BITS-1:0] max_power,
    output logic                         impossible
);
    import fdp_pkg::*;

    logic [VALUE_BITS-1:0] m_reg, n_reg, d_reg, p_reg, t_reg, total_reg, best_reg;
    logic [SQ_BITS-1:0]    dsq_reg;
    logic [EXP_BITS-1:0]   e_reg;
    logic                  best_valid_reg, ok_reg;
    logic [VALUE_BITS-1:0] div_a, div_b, div_q, div_r;
    logic                  div_done;

    // operand select for the shared divider
    always_comb
    begin
        case (cmd.div_sel)
            DIV_TRIAL:
            begin
                div_a = m_reg;
                div_b = d_reg;
            end
            DIV_LEG:
            begin
                div_a = t_reg;
                div_b = p_reg;
            end
            DIV_EXP:
            begin
                div_a = total_reg;
                div_b = VALUE_BITS'(e_reg);
            end
            default:
            begin
                div_a = m_reg;
                div_b = d_reg;
            end
        endcase
    end

    fdp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // factoring and legendre registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_reg   <= VALUE_BITS'(divisor_base);
            n_reg   <= VALUE_BITS'(factorial_arg);
            d_reg   <= VALUE_BITS'(2);
            dsq_reg <= SQ_BITS'(4);
            e_reg   <= '0;
        end
        if (cmd.trial_take)
        begin
            m_reg <= div_q;
            e_reg <= e_reg + EXP_BITS'(1);
        end
        if (cmd.trial_prime)
            p_reg <= d_reg;
        if (cmd.tail_prime)
        begin
            p_reg <= m_reg;
            e_reg <= EXP_BITS'(1);
        end
        // (d+1)^2 = d^2 + 2d + 1
        if (cmd.next_d)
        begin
            d_reg   <= d_reg + VALUE_BITS'(1);
            dsq_reg <= dsq_reg + (SQ_BITS'(d_reg) << 1) + SQ_BITS'(1);
            e_reg   <= '0;
        end
        if (cmd.leg_init)
        begin
            t_reg     <= n_reg;
            total_reg <= '0;
        end
        if (cmd.leg_acc)
        begin
            t_reg     <= div_q;
            total_reg <= total_reg + div_q;
        end
        if (cmd.fold && (!best_valid_reg || div_q < best_reg))
            best_reg <= div_q;
    end

    // running minimum flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
            ok_reg         <= 1'b1;
        end
        else if (cmd.load)
        begin
            best_valid_reg <= 1'b0;
            ok_reg         <= 1'b1;
        end
        else if (cmd.fold)
        begin
            best_valid_reg <= 1'b1;
            if (div_q == '0)
                ok_reg <= 1'b0;
        end
    end

    // status to the controller
    always_comb
    begin
        status.dsq_le_m  = dsq_reg <= SQ_BITS'(m_reg);
        status.m_gt1     = m_reg > VALUE_BITS'(1);
        status.div_done  = div_done;
        status.rem_zero  = div_r == '0;
        status.e_nonzero = e_reg != '0;
        status.t_zero    = t_reg == '0;
    end

    // result with saturation
    always_comb
    begin
        impossible = !ok_reg;
        if (!ok_reg)
            max_power = '0;
        else if (!best_valid_reg || best_reg > VALUE_BITS'(POWER_MAX))
            max_power = POWER_MAX;
        else
            max_power = OUT_BITS'(best_reg);
    end
endmodule

@@ src/fdp_ctrl.sv @@
module fdp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  fdp_pkg::status_t status,
    output fdp_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);
    import fdp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE       = 8'b0000_0001,
        S_TRIAL_CHK  = 8'b0000_0010,
        S_TRIAL_WAIT = 8'b0000_0100,
        S_LEG_START  = 8'b0000_1000,
        S_LEG_CHK    = 8'b0001_0000,
        S_LEG_WAIT   = 8'b0010_0000,
        S_EXP_WAIT   = 8'b0100_0000,
        S_FINISH     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   tail_reg, tail_next;

    // sequencing of factoring, legendre sums and folding
    always_comb
    begin
        state_next  = state_reg;
        tail_next   = tail_reg;
        cmd         = '0;
        cmd.div_sel = DIV_TRIAL;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    tail_next  = 1'b0;
                    state_next = S_TRIAL_CHK;
                end
            end
            S_TRIAL_CHK:
            begin
                // keep stripping d once it has divided m, whatever d*d is now
                if (status.dsq_le_m || status.e_nonzero)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_TRIAL;
                    state_next    = S_TRIAL_WAIT;
                end
                else if (status.m_gt1)
                begin
                    cmd.tail_prime = 1'b1;
                    tail_next      = 1'b1;
                    state_next     = S_LEG_START;
                end
                else
                    state_next = S_FINISH;
            end
            S_TRIAL_WAIT:
            begin
                if (status.div_done)
                begin
                    if (status.rem_zero)
                    begin
                        cmd.trial_take = 1'b1;
                        state_next     = S_TRIAL_CHK;
                    end
                    else if (status.e_nonzero)
                    begin
                        cmd.trial_prime = 1'b1;
                        state_next      = S_LEG_START;
                    end
                    else
                    begin
                        cmd.next_d = 1'b1;
                        state_next = S_TRIAL_CHK;
                    end
                end
            end
            S_LEG_START:
            begin
                cmd.leg_init = 1'b1;
                state_next   = S_LEG_CHK;
            end
            S_LEG_CHK:
            begin
                cmd.div_start = 1'b1;
                if (status.t_zero)
                begin
                    cmd.div_sel = DIV_EXP;
                    state_next  = S_EXP_WAIT;
                end
                else
                begin
                    cmd.div_sel = DIV_LEG;
                    state_next  = S_LEG_WAIT;
                end
            end
            S_LEG_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.leg_acc = 1'b1;
                    state_next  = S_LEG_CHK;
                end
            end
            S_EXP_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.fold = 1'b1;
                    if (tail_reg)
                        state_next = S_FINISH;
                    else
                    begin
                        cmd.next_d = 1'b1;
                        state_next = S_TRIAL_CHK;
                    end
                end
            end
            S_FINISH:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tail_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tail_reg  <= tail_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_FINISH;

`ifndef NO_ASSERTIONS
    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");
    // one result per item
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held");
    // result strobe frees the block on the next cycle
    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result");
    // divider only started from a check state
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (state_reg == S_TRIAL_CHK || state_reg == S_LEG_CHK))
        else $error("divider started from wrong state");
`endif
endmodule

@@ src/factorial_divisibility_power.sv @@
// Largest power k of m that divides n factorial. Pulse start with m on
// divisor_base and n on factorial_arg while busy is low; the item is taken at
// that edge and busy stays high until the result. The result appears on
// max_power and impossible for exactly one cycle, marked by done, and must be
// captured then: the block cannot be stalled. max_power saturates at 65535
// (also for m equal one); impossible is set, with max_power 0, when no
// positive power of m divides n!. All work runs through one shared 16-step
// restoring divider: trial division of m by every d with d*d <= m (one division per d
// plus one per factor found), and for each prime of m one division per term of its
// Legendre sum, the final zero term included, plus one to divide by the
// exponent; a new item is taken the cycle after done.
module factorial_divisibility_power (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [fdp_pkg::IN_BITS-1:0]  divisor_base,
    input  logic [fdp_pkg::IN_BITS-1:0]  factorial_arg,
    output logic                         busy,
    output logic                         done,
    output logic [fdp_pkg::OUT_BITS-1:0] max_power,
    output logic                         impossible
);
    import fdp_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer
    fdp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // registers and shared divider
    fdp_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .divisor_base  (divisor_base),
        .factorial_arg (factorial_arg),
        .status        (status),
        .max_power     (max_power),
        .impossible    (impossible)
    );
endmodule

@@ tb/sv/factorial_divisibility_power_checker.sv @@
module factorial_divisibility_power_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [fdp_pkg::IN_BITS-1:0]  divisor_base,
    input  logic [fdp_pkg::IN_BITS-1:0]  factorial_arg,
    input  logic                         done,
    input  logic [fdp_pkg::OUT_BITS-1:0] max_power,
    input  logic                         impossible,
    output int                           mismatches,
    output int                           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [fdp_pkg::IN_BITS-1:0]  m;
        logic [fdp_pkg::IN_BITS-1:0]  n;
        logic [fdp_pkg::OUT_BITS-1:0] power;
        logic                         impossible;
    } power_result_t;

    power_result_t expected_powers[$];
    int            fail_count;

    // exponent of prime p in n! as a sum of floor(n / p^i)
    function automatic longint unsigned prime_exponent_in_factorial(
        input longint unsigned n,
        input longint unsigned p
    );
        longint unsigned total;
        longint unsigned q;
        total = 0;
        q = p;
        while (q <= n) begin
            total += n / q;
            if (q > n / p)
                break;
            q *= p;
        end
        return total;
    endfunction

    // largest k with m^k dividing n!, zero and flagged when there is none
    function automatic power_result_t predict_power(
        input logic [fdp_pkg::IN_BITS-1:0] m_in,
        input logic [fdp_pkg::IN_BITS-1:0] n_in
    );
        longint unsigned mask;
        longint unsigned m;
        longint unsigned n;
        longint unsigned d;
        longint unsigned e;
        longint unsigned quot;
        longint unsigned best;
        bit              ok;
        power_result_t   r;
        mask = (64'd1 << fdp_pkg::VALUE_BITS) - 1;
        m    = 64'(m_in) & mask;
        n    = 64'(n_in) & mask;
        best = '1;
        ok   = 1'b1;
        r.m  = m_in;
        r.n  = n_in;
        // strip each trial divisor and fold its quotient into the minimum
        for (d = 2; d * d <= m; d++) begin
            e = 0;
            while (m % d == 0) begin
                m = m / d;
                e++;
            end
            if (e != 0) begin
                quot = prime_exponent_in_factorial(n, d) / e;
                if (quot < best)
                    best = quot;
                if (quot == 0)
                    ok = 1'b0;
            end
        end
        // leftover prime factor with exponent one
        if (m > 1) begin
            quot = prime_exponent_in_factorial(n, m);
            if (quot < best)
                best = quot;
            if (quot == 0)
                ok = 1'b0;
        end
        r.impossible = !ok;
        if (!ok)
            r.power = '0;
        else if (best > 64'(fdp_pkg::POWER_MAX))
            r.power = fdp_pkg::POWER_MAX;
        else
            r.power = best[fdp_pkg::OUT_BITS-1:0];
        return r;
    endfunction

    // compare each result with the oldest prediction, then log new items
    always @(posedge clk) begin
        power_result_t want;
        if (!rst_n) begin
            expected_powers.delete();
            fail_count = 0;
        end
        else begin
            if (done) begin
                if (expected_powers.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("%0t: result with no item pending: power %0d impossible %0b",
                                 $time, max_power, impossible);
                    fail_count++;
                end
                else begin
                    want = expected_powers.pop_front();
                    if (max_power !== want.power || impossible !== want.impossible) begin
                        if (fail_count < REPORT_LIMIT)
                            $display({"%0t: m %0d n %0d: expected power %0d impossible %0b,",
                                      " got power %0d impossible %0b"},
                                     $time, want.m, want.n, want.power, want.impossible,
                                     max_power, impossible);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                want = predict_power(divisor_base, factorial_arg);
                expected_powers.push_back(want);
            end
        end
        mismatches <= fail_count;
        pending    <= expected_powers.size();
    end

endmodule

@@ tb/sv/factorial_divisibility_power_tb.sv @@
module factorial_divisibility_power_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 100;
    // stall limit, well above the run time of a large prime m
    localparam int STALL_LIMIT     = 60000;
    localparam int TAIL_CYCLES     = 100;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         done;
    logic [fdp_pkg::IN_BITS-1:0]  divisor_base;
    logic [fdp_pkg::IN_BITS-1:0]  factorial_arg;
    logic [fdp_pkg::OUT_BITS-1:0] max_power;
    logic                         impossible;
    int                           mismatches;
    int                           pending;
    int                           idle_pct;
    int                           stall_cycles;

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    factorial_divisibility_power u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .divisor_base  (divisor_base),
        .factorial_arg (factorial_arg),
        .busy          (busy),
        .done          (done),
        .max_power     (max_power),
        .impossible    (impossible)
    );

    factorial_divisibility_power_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .divisor_base  (divisor_base),
        .factorial_arg (factorial_arg),
        .done          (done),
        .max_power     (max_power),
        .impossible    (impossible),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // present one item, idling at random, until the block takes it
    task automatic issue_pair(input logic [15:0] m, input logic [15:0] n);
        bit taken;
        taken = 1'b0;
        divisor_base  <= m;
        factorial_arg <= n;
        while (!taken) begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge clk);
            taken = start && !busy;
            @(negedge clk);
        end
    endtask

    // hold off until every item has its result
    task automatic wait_drained;
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // mostly small m to keep trial division short, some full range and prime powers
    task automatic issue_random_pair;
        int pm;
        int base;
        int n;
        case ($urandom_range(9))
            0, 1, 2: pm = $urandom_range(255, 1);
            3, 4:    pm = $urandom_range(4095, 2);
            5, 6, 7: pm = $urandom_range(65535, 1);
            default:
            begin
                case ($urandom_range(3))
                    0:       base = 2;
                    1:       base = 3;
                    2:       base = 5;
                    default: base = 7;
                endcase
                pm = base;
                repeat ($urandom_range(15))
                    if (pm * base <= 65535)
                        pm = pm * base;
            end
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4: n = $urandom_range(65535);
            5, 6, 7:       n = $urandom_range(255);
            default:       n = $urandom_range(pm);
        endcase
        issue_pair(pm[15:0], n[15:0]);
    endtask

    // stimulus
    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        divisor_base  = '0;
        factorial_arg = '0;
        idle_pct      = 24;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // m of one and zero saturate
        issue_pair(16'd1, 16'd0);
        issue_pair(16'd1, 16'd65535);
        issue_pair(16'd0, 16'd5);
        issue_pair(16'd0, 16'd0);
        // field extremes
        issue_pair(16'd65535, 16'd65535);
        issue_pair(16'd65535, 16'd0);
        issue_pair(16'd2, 16'd65535);
        issue_pair(16'd2, 16'd0);
        issue_pair(16'd2, 16'd1);
        // prime of m above n, and just reached
        issue_pair(16'd65521, 16'd65520);
        issue_pair(16'd65521, 16'd65521);
        issue_pair(16'd3, 16'd2);
        // exponent in n! below, at or above the exponent in m
        issue_pair(16'd8, 16'd3);
        issue_pair(16'd4, 16'd3);
        issue_pair(16'd4, 16'd4);
        issue_pair(16'd32768, 16'd15);
        issue_pair(16'd32768, 16'd16);
        // several primes
        issue_pair(16'd36, 16'd100);
        issue_pair(16'd65534, 16'd40000);
        issue_pair(16'd30030, 16'd13);

        repeat (ITEMS_PER_PHASE) issue_random_pair();
        wait_drained();
        idle_pct = 69;
        repeat (ITEMS_PER_PHASE) issue_random_pair();
        wait_drained();
        idle_pct = 0;
        repeat (ITEMS_PER_PHASE) issue_random_pair();
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("factorial_divisibility_power_tb OK");
        else
            $display("factorial_divisibility_power_tb NOT OK");
        $finish;
    end

    // watchdog on cycles with neither an item taken nor a result given
    always @(posedge clk) begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("factorial_divisibility_power_tb NOT OK");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule

@@ sim.f @@
src/fdp_pkg.sv
src/fdp_div.sv
src/fdp_datapath.sv
src/fdp_ctrl.sv
src/factorial_divisibility_power.sv
tb/sv/factorial_divisibility_power_checker.sv
tb/sv/factorial_divisibility_power_tb.sv
